### design/mte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_pkg
// Types, codes and the letter table shared by the multi-tap text entry block.
// ----------------------------------------------------------------------------
package mte_pkg;

  // largest field the hardware supports; max_len above this is clipped
  localparam logic [5:0] MaxField   = 6'd32;
  localparam logic [5:0] MaxLenRst  = 6'd16;

  localparam logic [1:0] OpDigit    = 2'd0;
  localparam logic [1:0] OpBack     = 2'd1;
  localparam logic [1:0] OpToggle   = 2'd2;
  localparam logic [1:0] OpStart    = 2'd3;

  localparam logic [1:0] ModeNum    = 2'd0;
  localparam logic [1:0] ModeUpper  = 2'd1;
  localparam logic [1:0] ModeLower  = 2'd2;

  localparam logic [3:0] KeyMax     = 4'd9;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharNone   = 8'h00;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] key;
    logic [1:0] start_mode;
  } in_item_t;

  typedef struct packed {
    logic       char_valid;
    logic [5:0] char_pos;
    logic [7:0] char_code;
    logic       blank_field;
    logic [1:0] entry_mode;
    logic       mode_changed;
    logic [5:0] text_length;
    logic       cursor_on;
    logic [4:0] cursor_pos;
  } out_item_t;

  typedef struct packed {
    logic [5:0] char_count;
    logic [5:0] text_len;
    logic [1:0] mode;
    logic       letter_pending;
    logic [3:0] last_key;
    logic [1:0] tap_index;
  } state_t;

  // three characters per key, tap index three reads as no character
  function automatic logic [7:0] letter_code(logic upper, logic [3:0] k, logic [1:0] t);
    logic [23:0] row;
    logic [7:0]  c;
    row = 24'h0;
    case (k)
      4'd0:    row = "-, ";
      4'd1:    row = upper ? "QZ." : "qz.";
      4'd2:    row = upper ? "ABC" : "abc";
      4'd3:    row = upper ? "DEF" : "def";
      4'd4:    row = upper ? "GHI" : "ghi";
      4'd5:    row = upper ? "JKL" : "jkl";
      4'd6:    row = upper ? "MNO" : "mno";
      4'd7:    row = upper ? "PRS" : "prs";
      4'd8:    row = upper ? "TUV" : "tuv";
      4'd9:    row = upper ? "WXY" : "wxy";
      default: row = 24'h0;
    endcase
    case (t)
      2'd0:    c = row[23:16];
      2'd1:    c = row[15:8];
      2'd2:    c = row[7:0];
      default: c = CharNone;
    endcase
    return c;
  endfunction

endpackage

### design/multitap_keypad_text_entry.sv
`timescale 1ns / 1ps
// a result word is registered and valid in the cycle after its event word is accepted
// throughput: one event per cycle unless a result waits with out_ready_i low, limited by the single result register
// in_ready_o drops only while a result waits and out_ready_i is low
// reset: text state cleared, numeric mode, max_len back to 16, no result held
// ----------------------------------------------------------------------------
// multitap_keypad_text_entry
// Multi-tap keypad text entry: digits, letters by repeated taps, backspace.
// ----------------------------------------------------------------------------
module multitap_keypad_text_entry (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [5:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mte_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mte_pkg::out_item_t out_data_o
);
  import mte_pkg::*;

  state_t     state_q, state_d;
  logic [5:0] max_len_q;
  out_item_t  result;
  logic       space;
  logic       accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = space;
  assign accept      = in_valid_i && space;

  mte_step u_step (
    .state_i   (state_q),
    .item_i    (in_data_i),
    .max_len_i (max_len_q),
    .state_o   (state_d),
    .result_o  (result)
  );

  mte_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .data_i      (result),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      max_len_q <= MaxLenRst;
    end else begin
      if (accept)      state_q   <= state_d;
      if (cfg_valid_i) max_len_q <= cfg_wdata_i;
    end
  end

endmodule

### design/mte_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_step
// Next-state and result logic for one keypad event.
// ----------------------------------------------------------------------------
module mte_step (
  input  mte_pkg::state_t    state_i,
  input  mte_pkg::in_item_t  item_i,
  input  logic [5:0]         max_len_i,
  output mte_pkg::state_t    state_o,
  output mte_pkg::out_item_t result_o
);
  import mte_pkg::*;

  logic [5:0] lim;
  logic       upper;
  logic [1:0] tap_nxt;
  logic [7:0] code_rep;
  logic [7:0] code_rep0;
  logic [7:0] code_new;
  logic [1:0] mode_nxt;
  logic       con;
  state_t     s;
  out_item_t  r;

  assign lim       = (max_len_i > MaxField) ? MaxField : max_len_i;
  assign upper     = (state_i.mode == ModeUpper);
  assign tap_nxt   = state_i.tap_index + 2'd1;
  assign code_rep  = letter_code(upper, state_i.last_key, tap_nxt);
  assign code_rep0 = letter_code(upper, state_i.last_key, 2'd0);
  assign code_new  = letter_code(upper, item_i.key, 2'd0);

  always_comb begin
    case (state_i.mode)
      ModeNum:   mode_nxt = ModeUpper;
      ModeUpper: mode_nxt = ModeLower;
      ModeLower: mode_nxt = ModeNum;
      default:   mode_nxt = ModeUpper;
    endcase
  end

  always_comb begin
    s = state_i;
    r = '0;
    case (item_i.op)
      OpBack: begin
        if (state_i.text_len != 6'd0) begin
          s.char_count = state_i.text_len - 6'd1;
          r.char_valid = 1'b1;
          r.char_pos   = s.char_count;
          r.char_code  = CharSpace;
        end else begin
          s.char_count = 6'd0;
        end
        if (state_i.mode != ModeNum) begin
          s.letter_pending = 1'b0;
          s.tap_index      = 2'd0;
        end
        s.text_len = s.char_count;
      end
      OpToggle: begin
        if (state_i.mode != ModeNum && state_i.letter_pending &&
            state_i.char_count < lim) begin
          s.char_count = state_i.char_count + 6'd1;
        end
        if (s.char_count == 6'd0) begin
          r.blank_field = 1'b1;
          s.text_len    = 6'd0;
        end
        if (state_i.letter_pending) begin
          s.letter_pending = 1'b0;
          s.tap_index      = 2'd0;
        end else begin
          s.mode = mode_nxt;
          if (mode_nxt != ModeNum) s.tap_index = 2'd0;
          r.mode_changed = 1'b1;
        end
        if (s.text_len > s.char_count) s.text_len = s.char_count;
      end
      OpStart: begin
        case (item_i.start_mode)
          ModeNum:   s.mode = ModeNum;
          ModeUpper: s.mode = ModeUpper;
          default:   s.mode = ModeLower;
        endcase
        s.letter_pending = 1'b0;
        s.last_key       = 4'd0;
        s.tap_index      = 2'd0;
      end
      default: begin
        if (item_i.key <= KeyMax && state_i.char_count < lim) begin
          if (state_i.mode != ModeNum) begin
            if (!state_i.letter_pending) begin
              // first tap opens a pending letter at the cursor
              if (state_i.char_count == 6'd0) r.blank_field = 1'b1;
              s.letter_pending = 1'b1;
              s.last_key       = item_i.key;
              r.char_valid     = 1'b1;
              r.char_pos       = state_i.char_count;
              r.char_code      = letter_code(upper, item_i.key, state_i.tap_index);
              s.text_len       = state_i.char_count + 6'd1;
            end else if (item_i.key == state_i.last_key) begin
              // repeat tap cycles through the key's letters
              if (code_rep == CharNone) begin
                s.tap_index = 2'd0;
                r.char_code = code_rep0;
              end else begin
                s.tap_index = tap_nxt;
                r.char_code = code_rep;
              end
              r.char_valid = 1'b1;
              r.char_pos   = state_i.char_count;
              s.text_len   = state_i.char_count + 6'd1;
            end else begin
              // different key commits and starts a new letter if room
              s.char_count = state_i.char_count + 6'd1;
              if (s.text_len > s.char_count) s.text_len = s.char_count;
              if (s.char_count < lim) begin
                s.tap_index  = 2'd0;
                s.last_key   = item_i.key;
                r.char_valid = 1'b1;
                r.char_pos   = s.char_count;
                r.char_code  = code_new;
                s.text_len   = s.char_count + 6'd1;
              end
            end
          end else begin
            if (state_i.char_count == 6'd0) r.blank_field = 1'b1;
            r.char_valid = 1'b1;
            r.char_pos   = state_i.char_count;
            r.char_code  = CharZero + {4'd0, item_i.key};
            s.char_count = state_i.char_count + 6'd1;
            s.text_len   = s.char_count;
          end
        end
      end
    endcase
    r.entry_mode  = s.mode;
    r.text_length = s.text_len;
  end

  assign con = (s.char_count < lim);

  always_comb begin
    result_o            = r;
    result_o.cursor_on  = con;
    result_o.cursor_pos = con ? s.char_count[4:0] : 5'd0;
  end

  assign state_o = s;

endmodule

### design/mte_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_out_reg
// Result register with valid/ready; takes a new word while the old one drains.
// ----------------------------------------------------------------------------
module mte_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  mte_pkg::out_item_t data_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mte_pkg::out_item_t out_data_o
);
  import mte_pkg::*;

  logic      valid_q, valid_d;
  out_item_t data_q;

  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) valid_d = 1'b0;
    if (load_i)      valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= data_i;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-tap keypad text entry block: a directed
// script of key events and field limits, then random event streams under
// several limits. Each display update is predicted in the bench and compared
// field by field, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import mte_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int PhaseCount   = 8;
  localparam int PhaseEvents  = 250;
  localparam int StallCycles  = 300;

  // upper-case key caps, three per key, keys 0 to 9 left to right
  localparam logic [8*30-1:0] KeyCaps = "-, QZ.ABCDEFGHIJKLMNOPRSTUVWXY";

  typedef enum logic [1:0] {RowEvent, RowEventTyped, RowSetLimit} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    in_item_t   ev;
    logic [5:0] limit_val;
    out_item_t  res;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [5:0] cfg_wdata = 6'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;

  // bench copy of the text entry state
  logic [5:0] typed_count = 6'd0;
  logic [5:0] stored_len = 6'd0;
  logic [1:0] cur_mode = ModeNum;
  logic       letter_open = 1'b0;
  logic [3:0] held_key = 4'd0;
  logic [1:0] tap_pos = 2'd0;
  logic [5:0] field_max = MaxLenRst;

  out_item_t   predicted_updates[$];
  script_row_t script_rows[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;
  bit          hold_off_req = 1'b0;

  always #5 clk = ~clk;

  multitap_keypad_text_entry dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  function automatic logic [7:0] tap_char(logic [1:0] m, logic [3:0] k, logic [1:0] t);
    int         idx;
    logic [7:0] c;
    idx = 29 - (k * 3 + t);
    c = (t == 2'd3 || k > KeyMax) ? CharNone : KeyCaps[8*idx +: 8];
    // lower-case row only differs in letters; the punctuation already has bit 5 set
    if (m != ModeUpper && c != CharNone) c = c | 8'h20;
    return c;
  endfunction

  function automatic out_item_t predict_display_update(in_item_t ev);
    out_item_t  r;
    logic [5:0] lim;
    logic       con;
    r = '0;
    lim = (field_max > MaxField) ? MaxField : field_max;
    case (ev.op)
      OpBack: begin
        if (stored_len != 6'd0) begin
          typed_count = stored_len - 6'd1;
          r.char_valid = 1'b1;
          r.char_pos = typed_count;
          r.char_code = CharSpace;
        end else begin
          typed_count = 6'd0;
        end
        if (cur_mode != ModeNum) begin
          letter_open = 1'b0;
          tap_pos = 2'd0;
        end
        stored_len = typed_count;
      end
      OpToggle: begin
        if (cur_mode != ModeNum && letter_open && typed_count < lim)
          typed_count = typed_count + 6'd1;
        if (typed_count == 6'd0) begin
          r.blank_field = 1'b1;
          stored_len = 6'd0;
        end
        if (letter_open) begin
          // toggle only commits the open letter
          letter_open = 1'b0;
          tap_pos = 2'd0;
        end else begin
          case (cur_mode)
            ModeNum:   cur_mode = ModeUpper;
            ModeUpper: cur_mode = ModeLower;
            ModeLower: cur_mode = ModeNum;
            default:   cur_mode = ModeUpper;
          endcase
          if (cur_mode != ModeNum) tap_pos = 2'd0;
          r.mode_changed = 1'b1;
        end
        if (stored_len > typed_count) stored_len = typed_count;
      end
      OpStart: begin
        cur_mode = (ev.start_mode == ModeNum) ? ModeNum :
                   (ev.start_mode == ModeUpper) ? ModeUpper : ModeLower;
        letter_open = 1'b0;
        held_key = 4'd0;
        tap_pos = 2'd0;
      end
      default: begin
        if (ev.key <= KeyMax && typed_count < lim) begin
          if (cur_mode == ModeNum) begin
            if (typed_count == 6'd0) begin
              r.blank_field = 1'b1;
              stored_len = 6'd0;
            end
            r.char_valid = 1'b1;
            r.char_pos = typed_count;
            r.char_code = CharZero + {4'd0, ev.key};
            typed_count = typed_count + 6'd1;
            stored_len = typed_count;
          end else if (!letter_open) begin
            if (typed_count == 6'd0) begin
              r.blank_field = 1'b1;
              stored_len = 6'd0;
            end
            letter_open = 1'b1;
            held_key = ev.key;
            r.char_valid = 1'b1;
            r.char_pos = typed_count;
            r.char_code = tap_char(cur_mode, held_key, tap_pos);
            stored_len = typed_count + 6'd1;
          end else if (ev.key == held_key) begin
            tap_pos = tap_pos + 2'd1;
            r.char_code = tap_char(cur_mode, held_key, tap_pos);
            if (r.char_code == CharNone) begin
              tap_pos = 2'd0;
              r.char_code = tap_char(cur_mode, held_key, 2'd0);
            end
            r.char_valid = 1'b1;
            r.char_pos = typed_count;
            stored_len = typed_count + 6'd1;
          end else begin
            // different key commits; a new letter starts only if it still fits
            typed_count = typed_count + 6'd1;
            if (stored_len > typed_count) stored_len = typed_count;
            if (typed_count < lim) begin
              tap_pos = 2'd0;
              held_key = ev.key;
              r.char_valid = 1'b1;
              r.char_pos = typed_count;
              r.char_code = tap_char(cur_mode, ev.key, 2'd0);
              stored_len = typed_count + 6'd1;
            end
          end
        end
      end
    endcase
    con = (typed_count < lim);
    r.entry_mode = cur_mode;
    r.text_length = stored_len;
    r.cursor_on = con;
    r.cursor_pos = con ? typed_count[4:0] : 5'd0;
    return r;
  endfunction

  function automatic string describe(out_item_t w);
    return $sformatf("cv=%0d pos=%0d code=%h blank=%0d mode=%0d chg=%0d len=%0d cur=%0d@%0d",
                     w.char_valid, w.char_pos, w.char_code, w.blank_field, w.entry_mode,
                     w.mode_changed, w.text_length, w.cursor_on, w.cursor_pos);
  endfunction

  function automatic script_row_t key_row(logic [1:0] op, logic [3:0] key, logic [1:0] sm);
    script_row_t row;
    row = '0;
    row.kind = RowEvent;
    row.ev.op = op;
    row.ev.key = key;
    row.ev.start_mode = sm;
    return row;
  endfunction

  function automatic script_row_t checked_row(logic [1:0] op, logic [3:0] key,
                                              logic cv, logic [5:0] pos, logic [7:0] code,
                                              logic blank, logic [5:0] len, logic [4:0] cpos);
    script_row_t row;
    row = key_row(op, key, 2'd0);
    row.kind = RowEventTyped;
    row.res.char_valid = cv;
    row.res.char_pos = pos;
    row.res.char_code = code;
    row.res.blank_field = blank;
    row.res.entry_mode = ModeNum;
    row.res.mode_changed = 1'b0;
    row.res.text_length = len;
    row.res.cursor_on = 1'b1;
    row.res.cursor_pos = cpos;
    return row;
  endfunction

  function automatic script_row_t limit_row(logic [5:0] v);
    script_row_t row;
    row = '0;
    row.kind = RowSetLimit;
    row.limit_val = v;
    return row;
  endfunction

  function automatic in_item_t random_event(logic [3:0] prev_key);
    in_item_t ev;
    int       roll;
    roll = $urandom_range(0, 99);
    ev.key = 4'($urandom_range(0, 15));
    ev.start_mode = 2'($urandom_range(0, 3));
    if (roll < 60) begin
      ev.op = OpDigit;
      // half the digit words repeat the last key to walk the tap cycle
      ev.key = (roll < 30) ? prev_key : 4'($urandom_range(0, 9));
      if ($urandom_range(0, 19) == 0) ev.key = 4'($urandom_range(10, 15));
    end else if (roll < 78) begin
      ev.op = OpBack;
    end else if (roll < 90) begin
      ev.op = OpToggle;
    end else begin
      ev.op = OpStart;
    end
    return ev;
  endfunction

  task automatic offer_event(input in_item_t ev, input bit typed, input out_item_t typed_res);
    out_item_t want;
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = predict_display_update(ev);
    predicted_updates.push_back(typed ? typed_res : want);
  endtask

  // field limit is only changed with nothing in flight
  task automatic set_field_limit(input logic [5:0] v);
    in_valid <= 1'b0;
    while (predicted_updates.size() != 0) @(posedge clk);
    cfg_wdata <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    field_max = v;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("multitap_keypad_text_entry test failed");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        for (int n = 0; n < StallCycles; n++) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 34);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    bit        bad;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_updates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected update word: %s", describe(out_data));
      end else begin
        want = predicted_updates.pop_front();
        bad = (out_data.char_valid   !== want.char_valid)   ||
              (out_data.char_pos     !== want.char_pos)     ||
              (out_data.char_code    !== want.char_code)    ||
              (out_data.blank_field  !== want.blank_field)  ||
              (out_data.entry_mode   !== want.entry_mode)   ||
              (out_data.mode_changed !== want.mode_changed) ||
              (out_data.text_length  !== want.text_length)  ||
              (out_data.cursor_on    !== want.cursor_on)    ||
              (out_data.cursor_pos   !== want.cursor_pos);
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("update mismatch at cycle %0d", cycle_count);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(out_data));
          end
        end
      end
    end
  end

  initial begin
    script_row_t row;
    logic [5:0]  phase_limit;
    logic [3:0]  last_digit;
    in_item_t    ev;

    // status after reset, ignored keys and the first numeric digits
    script_rows.push_back(checked_row(OpBack,  4'd0,  1'b0, 6'd0, CharNone, 1'b0, 6'd0, 5'd0));
    script_rows.push_back(checked_row(OpDigit, 4'd15, 1'b0, 6'd0, CharNone, 1'b0, 6'd0, 5'd0));
    script_rows.push_back(checked_row(OpDigit, 4'd0,  1'b1, 6'd0, 8'h30,    1'b1, 6'd1, 5'd1));
    script_rows.push_back(checked_row(OpDigit, 4'd9,  1'b1, 6'd1, 8'h39,    1'b0, 6'd2, 5'd2));
    script_rows.push_back(key_row(OpDigit, 4'd10, 2'd0));
    // letters: tap cycle with wrap, commit by a different key
    script_rows.push_back(key_row(OpToggle, 4'd0, 2'd0));
    script_rows.push_back(key_row(OpDigit, 4'd2, 2'd0));
    script_rows.push_back(key_row(OpDigit, 4'd2, 2'd0));
    script_rows.push_back(key_row(OpDigit, 4'd2, 2'd0));
    script_rows.push_back(key_row(OpDigit, 4'd2, 2'd0));
    script_rows.push_back(key_row(OpDigit, 4'd7, 2'd0));
    script_rows.push_back(key_row(OpDigit, 4'd1, 2'd0));
    script_rows.push_back(key_row(OpToggle, 4'd0, 2'd0));
    script_rows.push_back(key_row(OpToggle, 4'd0, 2'd0));
    script_rows.push_back(key_row(OpDigit, 4'd9, 2'd0));
    script_rows.push_back(key_row(OpDigit, 4'd9, 2'd0));
    script_rows.push_back(key_row(OpBack, 4'd0, 2'd0));
    script_rows.push_back(key_row(OpStart, 4'd0, 2'd3));
    script_rows.push_back(key_row(OpStart, 4'd0, 2'd0));
    // five characters held: limit of six gives a commit of the last letter that fits
    script_rows.push_back(limit_row(6'd6));
    script_rows.push_back(key_row(OpStart, 4'd0, 2'd1));
    script_rows.push_back(key_row(OpDigit, 4'd2, 2'd0));
    script_rows.push_back(key_row(OpDigit, 4'd3, 2'd0));
    script_rows.push_back(key_row(OpDigit, 4'd3, 2'd0));
    script_rows.push_back(key_row(OpToggle, 4'd0, 2'd0));
    script_rows.push_back(limit_row(6'd63));
    script_rows.push_back(key_row(OpDigit, 4'd5, 2'd0));
    script_rows.push_back(limit_row(6'd0));
    script_rows.push_back(key_row(OpDigit, 4'd4, 2'd0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script_rows[i]) begin
      row = script_rows[i];
      if (row.kind == RowSetLimit) set_field_limit(row.limit_val);
      else offer_event(row.ev, row.kind == RowEventTyped, row.res);
    end

    last_digit = 4'd0;
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0:       phase_limit = 6'd1;
        1:       phase_limit = 6'd32;
        2:       phase_limit = 6'd63;
        3:       phase_limit = 6'd0;
        4:       phase_limit = 6'd5;
        5:       phase_limit = 6'd20;
        default: phase_limit = 6'($urandom_range(1, 63));
      endcase
      set_field_limit(phase_limit);
      calm = (p == 2);
      for (int i = 0; i < PhaseEvents; i++) begin
        if (p == 1 && i == 40) hold_off_req = 1'b1;
        ev = random_event(last_digit);
        if (ev.op == OpDigit && ev.key <= KeyMax) last_digit = ev.key;
        offer_event(ev, 1'b0, '0);
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (predicted_updates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && predicted_updates.size() == 0) begin
      $display("multitap_keypad_text_entry test passed");
    end else begin
      $display("multitap_keypad_text_entry test failed");
    end
    $finish;
  end

endmodule
